[rtl/hslw_pkg.sv]
// ----------------------------------------------------------------------------
// hslw_pkg
// Shared constants, widths, register codes and the CORDIC angle table of the
// height/slope terrain layer weighter.
// ----------------------------------------------------------------------------
package hslw_pkg;

  // layer lanes
  localparam int NUM_LAYERS   = 4;
  localparam int SLOTS        = 4;
  localparam int LAYER_LIMIT  = (NUM_LAYERS < SLOTS) ? NUM_LAYERS : SLOTS;

  // heights and slope arithmetic
  localparam int HEIGHT_BITS  = 16;
  localparam int HQ_W         = 16;
  localparam int DIFF_W       = HEIGHT_BITS + 1;
  localparam int GAIN_W       = 24;
  localparam int GPROD_W      = DIFF_W + GAIN_W + 1;
  localparam int CORDIC_STEPS = (14 < 20) ? 14 : 20;
  localparam int CW           = 45;
  localparam int ZW           = 25;
  localparam int ATAN_W       = 22;
  localparam int SLOPE_W      = 14;
  localparam int SLOPE_MAX    = 11520;
  localparam int UNIT_Q24     = 1 << 24;

  // weights and normalisation
  localparam int ONE_Q16      = 65536;
  localparam int WT_W         = 17;
  localparam int SUM_W        = 19;
  localparam int NUM_W        = 26;
  localparam int DEN_W        = 20;
  localparam int BYTE_W       = 8;

  // configuration port
  localparam int CFG_W        = 64;
  localparam int PADDR_W      = 6;

  // pipeline length: entry, gain multiply, magnitude, two CORDIC passes with a
  // hand-over stage, slope, four layer stages, sum, setup, divider, output
  localparam int LAT          = 20 + 2 * CORDIC_STEPS;

  typedef enum logic [2:0] {
    REG_RULE_0       = 3'd0,
    REG_RULE_1       = 3'd1,
    REG_RULE_2       = 3'd2,
    REG_RULE_3       = 3'd3,
    REG_LAYERS       = 3'd4,
    REG_FALLBACK     = 3'd5,
    REG_SLOPE_GAIN_X = 3'd6,
    REG_SLOPE_GAIN_Y = 3'd7
  } cfg_reg_t;

  // atan(2^-i) in degrees * 65536
  localparam logic [ATAN_W-1:0] ATAN_TAB [20] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379,
    22'd117304,  22'd58666,   22'd29335,  22'd14668,  22'd7334,
    22'd3667,    22'd1833,    22'd917,    22'd458,    22'd229,
    22'd115,     22'd57,      22'd29,     22'd14,     22'd7
  };

  // x after vectoring (1.0, 0): CORDIC gain applied to unity in Q24
  function automatic logic signed [CW-1:0] cordic_unit_gain();
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    x = CW'(UNIT_Q24);
    y = '0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
      end else begin
        x = x - ys;
        y = y + xs;
      end
    end
    return x;
  endfunction

  localparam logic signed [CW-1:0] KX = cordic_unit_gain();

endpackage

[rtl/hslw_in_if.sv]
// ----------------------------------------------------------------------------
// hslw_in_if
// Vertex request channel: centre height and four neighbour heights.
// ----------------------------------------------------------------------------
interface hslw_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] height_center;
  logic [15:0] height_left;
  logic [15:0] height_right;
  logic [15:0] height_up;
  logic [15:0] height_down;

  modport source (
    output valid, height_center, height_left, height_right, height_up,
           height_down,
    input  ready
  );
  modport sink (
    input  valid, height_center, height_left, height_right, height_up,
           height_down,
    output ready
  );
endinterface

[rtl/hslw_out_if.sv]
// ----------------------------------------------------------------------------
// hslw_out_if
// Weight result channel: one byte per layer.
// ----------------------------------------------------------------------------
interface hslw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] weight_zero;
  logic [7:0] weight_one;
  logic [7:0] weight_two;
  logic [7:0] weight_three;

  modport source (
    output valid, weight_zero, weight_one, weight_two, weight_three,
    input  ready
  );
  modport sink (
    input  valid, weight_zero, weight_one, weight_two, weight_three,
    output ready
  );
endinterface

[rtl/height_slope_layer_weighter_top.sv]
// ----------------------------------------------------------------------------
// height_slope_layer_weighter_top
// Per-vertex splat weights from height and CORDIC slope, with fallback layer
// and pipelined restoring-divider normalisation when the sum exceeds one.
//
//   channel  direction  handshake             payload
//   in_ch    in         valid/ready           five 16-bit raw heights
//   out_ch   out        valid/ready           four weight bytes
//   cfg_*    in         APB write, pready=1   eight registers at 8*i, 64 bits
//
// One vertex enters per cycle while the output register is empty or taken.
// The depth is set by the two chained CORDIC vectoring passes, one
// micro-rotation per stage, and the eight-stage quotient divider.
// All stages advance together while the output register is empty or taken;
// a stalled result holds the whole pipeline, so nothing is lost or repeated.
// Reset clears valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module height_slope_layer_weighter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  hslw_in_if.sink                       in_ch,
  hslw_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [hslw_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [hslw_pkg::CFG_W-1:0]    cfg_pwdata,
  output logic [hslw_pkg::CFG_W-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  localparam int N  = hslw_pkg::CORDIC_STEPS;
  localparam int L  = hslw_pkg::SLOTS;
  localparam int CW = hslw_pkg::CW;
  localparam int ZW = hslw_pkg::ZW;
  localparam int HB = hslw_pkg::HEIGHT_BITS;

  // configuration registers
  logic [hslw_pkg::CFG_W-1:0]  rule_r [L];
  logic [2:0]                  layers_r;
  logic [1:0]                  fb_sel_r;
  logic [hslw_pkg::GAIN_W-1:0] gain_x_r;
  logic [hslw_pkg::GAIN_W-1:0] gain_y_r;

  hslw_pkg::cfg_reg_t cfg_idx;
  logic               cfg_wr;

  assign cfg_idx    = hslw_pkg::cfg_reg_t'(cfg_paddr[5:3]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < L; l++) rule_r[l] <= '0;
      layers_r <= 3'd1;
      fb_sel_r <= 2'd0;
      gain_x_r <= hslw_pkg::GAIN_W'(65536);
      gain_y_r <= hslw_pkg::GAIN_W'(65536);
    end else if (cfg_wr) begin
      case (cfg_idx)
        hslw_pkg::REG_RULE_0:       rule_r[0] <= cfg_pwdata;
        hslw_pkg::REG_RULE_1:       rule_r[1] <= cfg_pwdata;
        hslw_pkg::REG_RULE_2:       rule_r[2] <= cfg_pwdata;
        hslw_pkg::REG_RULE_3:       rule_r[3] <= cfg_pwdata;
        hslw_pkg::REG_LAYERS:       layers_r  <= cfg_pwdata[2:0];
        hslw_pkg::REG_FALLBACK:     fb_sel_r  <= cfg_pwdata[1:0];
        hslw_pkg::REG_SLOPE_GAIN_X: gain_x_r  <= cfg_pwdata[hslw_pkg::GAIN_W-1:0];
        hslw_pkg::REG_SLOPE_GAIN_Y: gain_y_r  <= cfg_pwdata[hslw_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      hslw_pkg::REG_RULE_0:       cfg_prdata = rule_r[0];
      hslw_pkg::REG_RULE_1:       cfg_prdata = rule_r[1];
      hslw_pkg::REG_RULE_2:       cfg_prdata = rule_r[2];
      hslw_pkg::REG_RULE_3:       cfg_prdata = rule_r[3];
      hslw_pkg::REG_LAYERS:       cfg_prdata = hslw_pkg::CFG_W'(layers_r);
      hslw_pkg::REG_FALLBACK:     cfg_prdata = hslw_pkg::CFG_W'(fb_sel_r);
      hslw_pkg::REG_SLOPE_GAIN_X: cfg_prdata = hslw_pkg::CFG_W'(gain_x_r);
      hslw_pkg::REG_SLOPE_GAIN_Y: cfg_prdata = hslw_pkg::CFG_W'(gain_y_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  // active layer count and fallback lane
  logic [2:0] active;
  logic [1:0] fb;
  logic [L-1:0] lane_use;

  always_comb begin
    if (layers_r == 3'd0) begin
      active = 3'd1;
    end else if (layers_r > 3'(hslw_pkg::LAYER_LIMIT)) begin
      active = 3'(hslw_pkg::LAYER_LIMIT);
    end else begin
      active = layers_r;
    end
    if ({1'b0, fb_sel_r} < active) begin
      fb = fb_sel_r;
    end else begin
      fb = 2'(active - 3'd1);
    end
    for (int l = 0; l < L; l++) begin
      lane_use[l] = (3'(l) < active) && (2'(l) != fb);
    end
  end

  // pipeline advance
  logic vld_r [hslw_pkg::LAT];
  logic en;

  assign en          = !vld_r[hslw_pkg::LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < hslw_pkg::LAT; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_ch.valid;
      for (int s = 1; s < hslw_pkg::LAT; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  // datapath registers
  logic [hslw_pkg::HQ_W-1:0]          hq0_r, hq1_r;
  logic signed [hslw_pkg::DIFF_W-1:0] dx0_r, dy0_r;
  logic signed [hslw_pkg::GPROD_W-1:0] gx1_r, gy1_r;
  logic signed [CW-1:0]               ax_r [N+1];
  logic signed [CW-1:0]               ay_r [N+1];
  logic [hslw_pkg::HQ_W-1:0]          hqa_r [N+1];
  logic signed [CW-1:0]               bx_r [N+1];
  logic signed [CW-1:0]               by_r [N+1];
  logic signed [ZW-1:0]               bz_r [N+1];
  logic [hslw_pkg::HQ_W-1:0]          hqb_r [N+1];
  logic [hslw_pkg::SLOPE_W-1:0]       slope3_r;
  logic [hslw_pkg::HQ_W-1:0]          hq3_r;
  logic                               hneg4_r [L];
  logic                               sneg4_r [L];
  logic [31:0]                        hprod4_r [L];
  logic [29:0]                        sprod4_r [L];
  logic [hslw_pkg::WT_W-1:0]          h5_r [L];
  logic [hslw_pkg::WT_W-1:0]          s5_r [L];
  logic [33:0]                        prod6_r [L];
  logic [hslw_pkg::WT_W-1:0]          w7_r [L];
  logic [hslw_pkg::WT_W-1:0]          w8_r [L];
  logic [hslw_pkg::SUM_W-1:0]         sum8_r;
  logic [hslw_pkg::NUM_W-1:0]         rem_r [9][L];
  logic [hslw_pkg::BYTE_W-1:0]        quo_r [9][L];
  logic [hslw_pkg::BYTE_W-1:0]        bn_r [9][L];
  logic [hslw_pkg::DEN_W-1:0]         den_r [9];
  logic                               ovf_r [9];
  logic [hslw_pkg::BYTE_W-1:0]        out_w_r [L];

  logic signed [hslw_pkg::GAIN_W:0]   gain_xs, gain_ys;
  assign gain_xs = $signed({1'b0, gain_x_r});
  assign gain_ys = $signed({1'b0, gain_y_r});

  // combinational helpers for the lane stages
  logic signed [hslw_pkg::HQ_W:0]      hd [L];
  logic signed [hslw_pkg::SLOPE_W:0]   sd [L];
  logic [hslw_pkg::WT_W-1:0]           h_nxt [L];
  logic [hslw_pkg::WT_W-1:0]           s_nxt [L];
  logic [30:0]                         s_sh [L];
  logic [ZW-1:0]                       z_pos;
  logic [ZW-1:0]                       z_rnd;
  logic [hslw_pkg::SLOPE_W-1:0]        slope_nxt;
  logic [hslw_pkg::SUM_W-1:0]          sum_nxt;
  logic                                ovf_nxt;
  logic [hslw_pkg::WT_W-1:0]           weff [L];
  logic [24:0]                         bn_full [L];
  logic [hslw_pkg::NUM_W:0]            trial [8][L];

  always_comb begin
    // slope from the final angle: floor at zero, round to Q7.7, clamp
    z_pos = bz_r[N][ZW-1] ? '0 : ZW'(bz_r[N]);
    z_rnd = (z_pos + ZW'(256)) >> 9;
    if (z_rnd > ZW'(hslw_pkg::SLOPE_MAX)) begin
      slope_nxt = hslw_pkg::SLOPE_W'(hslw_pkg::SLOPE_MAX);
    end else begin
      slope_nxt = z_rnd[hslw_pkg::SLOPE_W-1:0];
    end

    for (int l = 0; l < L; l++) begin
      // soft step differences
      hd[l] = $signed({1'b0, hq3_r}) - $signed({1'b0, rule_r[l][17:2]});
      sd[l] = $signed({1'b0, slope3_r}) - $signed({1'b0, rule_r[l][47:34]});

      // clamp the height step; a disabled step counts as one
      if (!rule_r[l][0]) begin
        h_nxt[l] = hslw_pkg::WT_W'(hslw_pkg::ONE_Q16);
      end else if (hneg4_r[l]) begin
        h_nxt[l] = '0;
      end else if (rule_r[l][33:18] == 16'd0) begin
        h_nxt[l] = hslw_pkg::WT_W'(hslw_pkg::ONE_Q16);
      end else if (hprod4_r[l] > 32'(hslw_pkg::ONE_Q16)) begin
        h_nxt[l] = hslw_pkg::WT_W'(hslw_pkg::ONE_Q16);
      end else begin
        h_nxt[l] = hprod4_r[l][hslw_pkg::WT_W-1:0];
      end

      // clamp the slope step, Q1.15 product moved up to Q0.16
      s_sh[l] = {sprod4_r[l], 1'b0};
      if (!rule_r[l][1]) begin
        s_nxt[l] = hslw_pkg::WT_W'(hslw_pkg::ONE_Q16);
      end else if (sneg4_r[l]) begin
        s_nxt[l] = '0;
      end else if (rule_r[l][63:48] == 16'd0) begin
        s_nxt[l] = hslw_pkg::WT_W'(hslw_pkg::ONE_Q16);
      end else if (s_sh[l] > 31'(hslw_pkg::ONE_Q16)) begin
        s_nxt[l] = hslw_pkg::WT_W'(hslw_pkg::ONE_Q16);
      end else begin
        s_nxt[l] = s_sh[l][hslw_pkg::WT_W-1:0];
      end
    end

    // sum of the non-fallback weights
    sum_nxt = '0;
    for (int l = 0; l < L; l++) sum_nxt = sum_nxt + hslw_pkg::SUM_W'(w7_r[l]);

    // fallback remainder and plain byte rounding
    ovf_nxt = sum8_r > hslw_pkg::SUM_W'(hslw_pkg::ONE_Q16);
    for (int l = 0; l < L; l++) begin
      if ((2'(l) == fb) && !ovf_nxt) begin
        weff[l] = hslw_pkg::WT_W'(hslw_pkg::SUM_W'(hslw_pkg::ONE_Q16) - sum8_r);
      end else begin
        weff[l] = w8_r[l];
      end
      bn_full[l] = 25'(weff[l]) * 25'd255 + 25'd32768;
    end

    // restoring divider trial subtractions, one quotient bit per stage
    for (int k = 0; k < 8; k++) begin
      for (int l = 0; l < L; l++) begin
        trial[k][l] = {1'b0, rem_r[k][l]} - ((hslw_pkg::NUM_W+1)'(den_r[k]) << (7 - k));
      end
    end
  end

  // pipeline stages
  always_ff @(posedge clk) begin
    if (en) begin
      // entry: central differences
      hq0_r <= hslw_pkg::HQ_W'(in_ch.height_center[HB-1:0]) << (hslw_pkg::HQ_W - HB);
      dx0_r <= $signed(hslw_pkg::DIFF_W'(in_ch.height_right[HB-1:0]))
             - $signed(hslw_pkg::DIFF_W'(in_ch.height_left[HB-1:0]));
      dy0_r <= $signed(hslw_pkg::DIFF_W'(in_ch.height_down[HB-1:0]))
             - $signed(hslw_pkg::DIFF_W'(in_ch.height_up[HB-1:0]));

      // per-axis gain
      gx1_r <= dx0_r * gain_xs;
      gy1_r <= dy0_r * gain_ys;
      hq1_r <= hq0_r;

      // magnitudes
      ax_r[0]  <= gx1_r[hslw_pkg::GPROD_W-1] ? -CW'(gx1_r) : CW'(gx1_r);
      ay_r[0]  <= gy1_r[hslw_pkg::GPROD_W-1] ? -CW'(gy1_r) : CW'(gy1_r);
      hqa_r[0] <= hq1_r;

      // first vectoring pass: x becomes K times the gradient magnitude
      for (int i = 0; i < N; i++) begin
        if (ay_r[i] > 0) begin
          ax_r[i+1] <= ax_r[i] + (ay_r[i] >>> i);
          ay_r[i+1] <= ay_r[i] - (ax_r[i] >>> i);
        end else begin
          ax_r[i+1] <= ax_r[i] - (ay_r[i] >>> i);
          ay_r[i+1] <= ay_r[i] + (ax_r[i] >>> i);
        end
        hqa_r[i+1] <= hqa_r[i];
      end

      // hand-over to the angle pass
      bx_r[0]  <= hslw_pkg::KX;
      by_r[0]  <= ax_r[N];
      bz_r[0]  <= '0;
      hqb_r[0] <= hqa_r[N];

      // second vectoring pass: angle of (K, K * magnitude)
      for (int i = 0; i < N; i++) begin
        if (by_r[i] > 0) begin
          bx_r[i+1] <= bx_r[i] + (by_r[i] >>> i);
          by_r[i+1] <= by_r[i] - (bx_r[i] >>> i);
          bz_r[i+1] <= bz_r[i] + ZW'(hslw_pkg::ATAN_TAB[i]);
        end else begin
          bx_r[i+1] <= bx_r[i] - (by_r[i] >>> i);
          by_r[i+1] <= by_r[i] + (bx_r[i] >>> i);
          bz_r[i+1] <= bz_r[i] - ZW'(hslw_pkg::ATAN_TAB[i]);
        end
        hqb_r[i+1] <= hqb_r[i];
      end

      // slope in Q7.7 degrees
      slope3_r <= slope_nxt;
      hq3_r    <= hqb_r[N];

      for (int l = 0; l < L; l++) begin
        // step gains
        hneg4_r[l]  <= hd[l][hslw_pkg::HQ_W];
        sneg4_r[l]  <= sd[l][hslw_pkg::SLOPE_W];
        hprod4_r[l] <= 32'(hd[l][hslw_pkg::HQ_W-1:0]) * 32'(rule_r[l][33:18]);
        sprod4_r[l] <= 30'(sd[l][hslw_pkg::SLOPE_W-1:0]) * 30'(rule_r[l][63:48]);

        // clamped steps
        h5_r[l] <= h_nxt[l];
        s5_r[l] <= s_nxt[l];

        // combined step
        prod6_r[l] <= 34'(h5_r[l]) * 34'(s5_r[l]);

        // rounded layer weight, fallback and unused lanes zeroed
        w7_r[l] <= lane_use[l] ? hslw_pkg::WT_W'((prod6_r[l] + 34'd32768) >> 16) : '0;
        w8_r[l] <= w7_r[l];

        // divider setup
        rem_r[0][l] <= hslw_pkg::NUM_W'(w8_r[l]) * hslw_pkg::NUM_W'(510)
                     + hslw_pkg::NUM_W'(sum8_r);
        quo_r[0][l] <= '0;
        bn_r[0][l]  <= bn_full[l][23:16];
      end
      sum8_r   <= sum_nxt;
      den_r[0] <= {sum8_r, 1'b0};
      ovf_r[0] <= ovf_nxt;

      // quotient bits, most significant first
      for (int k = 0; k < 8; k++) begin
        for (int l = 0; l < L; l++) begin
          if (!trial[k][l][hslw_pkg::NUM_W]) begin
            rem_r[k+1][l] <= trial[k][l][hslw_pkg::NUM_W-1:0];
            quo_r[k+1][l] <= quo_r[k][l] | (hslw_pkg::BYTE_W'(1) << (7 - k));
          end else begin
            rem_r[k+1][l] <= rem_r[k][l];
            quo_r[k+1][l] <= quo_r[k][l];
          end
          bn_r[k+1][l] <= bn_r[k][l];
        end
        den_r[k+1] <= den_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end

      // output register
      for (int l = 0; l < L; l++) begin
        out_w_r[l] <= ovf_r[8] ? quo_r[8][l] : bn_r[8][l];
      end
    end
  end

  assign out_ch.valid        = vld_r[hslw_pkg::LAT-1];
  assign out_ch.weight_zero  = out_w_r[0];
  assign out_ch.weight_one   = out_w_r[1];
  assign out_ch.weight_two   = out_w_r[2];
  assign out_ch.weight_three = out_w_r[3];

endmodule
